// ----- rtl/core/ccc_pkg.sv -----
// Shared types and constants for the circle-circle contact core.
// No dependencies; every module of the core imports this package.
package ccc_pkg;

  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps  = 31;
  localparam int unsigned DivLanes  = 4;
  localparam int unsigned Q14One    = 16384;

  // Lanes of the shared divider.
  typedef enum logic [1:0] {
    LaneNx = 2'd0,
    LaneNy = 2'd1,
    LanePx = 2'd2,
    LanePy = 2'd3
  } ccc_lane_e;

  typedef logic [63:0] ccc_dw_t;
  typedef logic [30:0] ccc_quo_t;

  // Side data that travels beside the square root.
  typedef struct packed {
    logic               hit;
    logic               sgx;
    logic               sgy;
    logic [31:0]        mx;
    logic [31:0]        my;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic [30:0]        ra;
    logic [31:0]        rsum;
  } ccc_ctx_t;

  // Side data that travels beside the divider.
  typedef struct packed {
    logic               hit;
    logic               sgx;
    logic               sgy;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic [31:0]        m;
    logic [31:0]        rsum;
  } ccc_dctx_t;

endpackage

// ----- rtl/core/circle_circle_contact_core.sv -----
// Circle-circle contact core: top level with the divider setup and output stages.
// Instantiates ccc_front, ccc_sqrt and ccc_div; depends on ccc_pkg.

// One circle pair is accepted every cycle unless the pipeline holds, and its result passes
// through three front stages (differences, squares, overlap test), 32 stages of the
// bit-per-stage square root, one setup stage, 31 stages of the shared four-lane
// divider and the output register. The root and divider stage counts set the
// pipeline depth. The whole pipeline holds when a result waits on out_ready_i, so
// in_ready_o follows the output register. A pair without contact returns hit
// low and all other fields zero.
module circle_circle_contact_core import ccc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] a_x_i,
  input  logic signed [31:0] a_y_i,
  input  logic [30:0]        a_radius_i,
  input  logic signed [31:0] b_x_i,
  input  logic signed [31:0] b_y_i,
  input  logic [30:0]        b_radius_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               hit_o,
  output logic signed [15:0] normal_x_o,
  output logic signed [15:0] normal_y_o,
  output logic signed [31:0] point_x_o,
  output logic signed [31:0] point_y_o,
  output logic [31:0]        depth_o
);

  logic        adv;
  logic        fv, sv, dv;
  logic [63:0] fs;
  ccc_ctx_t    fctx, sctx;
  logic [31:0] sm;

  logic        vp_q;
  ccc_dw_t     num_q [DivLanes];
  ccc_dw_t     num_d [DivLanes];
  logic [31:0] den_q;
  ccc_dctx_t   dctx_q, dctx_d, octx;
  ccc_quo_t    quo [DivLanes];

  logic               out_valid_q, hit_q, hit_d;
  logic signed [15:0] nx_q, ny_q, nx_d, ny_d;
  logic signed [31:0] px_q, py_q, px_d, py_d;
  logic [31:0]        depth_q, depth_d;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  ccc_front u_front (
    .clk_i,
    .rst_ni,
    .adv_i      (adv),
    .valid_i    (in_valid_i),
    .a_x_i,
    .a_y_i,
    .a_radius_i,
    .b_x_i,
    .b_y_i,
    .b_radius_i,
    .valid_o    (fv),
    .s_o        (fs),
    .ctx_o      (fctx)
  );

  ccc_sqrt u_sqrt (
    .clk_i,
    .rst_ni,
    .adv_i   (adv),
    .valid_i (fv),
    .s_i     (fs),
    .ctx_i   (fctx),
    .valid_o (sv),
    .m_o     (sm),
    .ctx_o   (sctx)
  );

  // Dividends carry half the divisor so the quotient rounds half away from zero.
  always_comb begin
    logic [31:0] half;
    logic [62:0] prx, pry;
    half = sm >> 1;
    prx  = sctx.mx * sctx.ra;
    pry  = sctx.my * sctx.ra;
    num_d[LaneNx] = {18'd0, sctx.mx, 14'd0} + 64'(half);
    num_d[LaneNy] = {18'd0, sctx.my, 14'd0} + 64'(half);
    num_d[LanePx] = 64'(prx) + 64'(half);
    num_d[LanePy] = 64'(pry) + 64'(half);
    dctx_d.hit  = sctx.hit;
    dctx_d.sgx  = sctx.sgx;
    dctx_d.sgy  = sctx.sgy;
    dctx_d.ax   = sctx.ax;
    dctx_d.ay   = sctx.ay;
    dctx_d.m    = sm;
    dctx_d.rsum = sctx.rsum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (adv) begin
      vp_q <= sv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < DivLanes; l++) begin
        num_q[l] <= num_d[l];
      end
      den_q  <= sm;
      dctx_q <= dctx_d;
    end
  end

  ccc_div u_div (
    .clk_i,
    .rst_ni,
    .adv_i   (adv),
    .valid_i (vp_q),
    .num_i   (num_q),
    .den_i   (den_q),
    .ctx_i   (dctx_q),
    .valid_o (dv),
    .quo_o   (quo),
    .ctx_o   (octx)
  );

  always_comb begin
    logic [14:0]        magx, magy;
    logic signed [32:0] ex, ey, sx, sy;
    magx = (quo[LaneNx] > 31'(Q14One)) ? 15'(Q14One) : quo[LaneNx][14:0];
    magy = (quo[LaneNy] > 31'(Q14One)) ? 15'(Q14One) : quo[LaneNy][14:0];
    ex   = {octx.ax[31], octx.ax};
    ey   = {octx.ay[31], octx.ay};
    sx   = octx.sgx ? ex - {2'b00, quo[LanePx]} : ex + {2'b00, quo[LanePx]};
    sy   = octx.sgy ? ey - {2'b00, quo[LanePy]} : ey + {2'b00, quo[LanePy]};
    hit_d   = octx.hit;
    nx_d    = '0;
    ny_d    = '0;
    px_d    = '0;
    py_d    = '0;
    depth_d = '0;
    if (octx.hit) begin
      nx_d = octx.sgx ? -{1'b0, magx} : {1'b0, magx};
      ny_d = octx.sgy ? -{1'b0, magy} : {1'b0, magy};
      if (sx[32] != sx[31]) begin
        px_d = sx[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
        px_d = sx[31:0];
      end
      if (sy[32] != sy[31]) begin
        py_d = sy[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
        py_d = sy[31:0];
      end
      depth_d = octx.rsum - octx.m;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_q   <= hit_d;
      nx_q    <= nx_d;
      ny_q    <= ny_d;
      px_q    <= px_d;
      py_q    <= py_d;
      depth_q <= depth_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign normal_x_o  = nx_q;
  assign normal_y_o  = ny_q;
  assign point_x_o   = px_q;
  assign point_y_o   = py_q;
  assign depth_o     = depth_q;

  a_depth_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> depth_o != 32'd0)
    else $error("contact with zero depth");

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> normal_x_o == 16'sd0 && normal_y_o == 16'sd0 &&
      point_x_o == 32'sd0 && point_y_o == 32'sd0 && depth_o == 32'd0)
    else $error("miss with nonzero fields");

  a_normal_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> normal_x_o != 16'sd0 || normal_y_o != 16'sd0)
    else $error("contact with zero normal");

  a_normal_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> normal_x_o <= 16'sd16384 && normal_x_o >= -16'sd16384 &&
      normal_y_o <= 16'sd16384 && normal_y_o >= -16'sd16384)
    else $error("normal component out of range");

endmodule

// ----- rtl/core/ccc_front.sv -----
// Front end of the contact core: center differences, squares and the overlap test.
// Three register stages; depends on ccc_pkg.
module ccc_front import ccc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               valid_i,
  input  logic signed [31:0] a_x_i,
  input  logic signed [31:0] a_y_i,
  input  logic [30:0]        a_radius_i,
  input  logic signed [31:0] b_x_i,
  input  logic signed [31:0] b_y_i,
  input  logic [30:0]        b_radius_i,
  output logic               valid_o,
  output logic [63:0]        s_o,
  output ccc_ctx_t           ctx_o
);

  logic               v1_q, v2_q, v3_q;
  logic signed [32:0] dx1_q, dy1_q;
  logic [31:0]        rsum1_q, rsum2_q;
  logic signed [31:0] ax1_q, ay1_q, ax2_q, ay2_q;
  logic [30:0]        ra1_q, ra2_q;
  logic [31:0]        mx_d, my_d, mx2_q, my2_q;
  logic               sgx2_q, sgy2_q;
  logic [63:0]        sx_d, sy_d, rr_d, sx2_q, sy2_q, rr2_q;
  logic [64:0]        s_d;
  logic [63:0]        s3_q;
  ccc_ctx_t           ctx_d, ctx3_q;

  always_comb begin
    mx_d = dx1_q[32] ? 32'(-dx1_q) : dx1_q[31:0];
    my_d = dy1_q[32] ? 32'(-dy1_q) : dy1_q[31:0];
    sx_d = mx_d * mx_d;
    sy_d = my_d * my_d;
    rr_d = rsum1_q * rsum1_q;
  end

  // The sum may carry into bit 64; such a distance is never a contact.
  always_comb begin
    s_d        = {1'b0, sx2_q} + {1'b0, sy2_q};
    ctx_d.hit  = (s_d != 65'd0) && (s_d < {1'b0, rr2_q});
    ctx_d.sgx  = sgx2_q;
    ctx_d.sgy  = sgy2_q;
    ctx_d.mx   = mx2_q;
    ctx_d.my   = my2_q;
    ctx_d.ax   = ax2_q;
    ctx_d.ay   = ay2_q;
    ctx_d.ra   = ra2_q;
    ctx_d.rsum = rsum2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dx1_q   <= {b_x_i[31], b_x_i} - {a_x_i[31], a_x_i};
      dy1_q   <= {b_y_i[31], b_y_i} - {a_y_i[31], a_y_i};
      rsum1_q <= {1'b0, a_radius_i} + {1'b0, b_radius_i};
      ax1_q   <= a_x_i;
      ay1_q   <= a_y_i;
      ra1_q   <= a_radius_i;
      sx2_q   <= sx_d;
      sy2_q   <= sy_d;
      rr2_q   <= rr_d;
      mx2_q   <= mx_d;
      my2_q   <= my_d;
      sgx2_q  <= dx1_q[32];
      sgy2_q  <= dy1_q[32];
      rsum2_q <= rsum1_q;
      ax2_q   <= ax1_q;
      ay2_q   <= ay1_q;
      ra2_q   <= ra1_q;
      s3_q    <= s_d[63:0];
      ctx3_q  <= ctx_d;
    end
  end

  assign valid_o = v3_q;
  assign s_o     = s3_q;
  assign ctx_o   = ctx3_q;

endmodule

// ----- rtl/core/ccc_sqrt.sv -----
// Pipelined integer square root, one result bit per register stage.
// Carries the contact side data alongside; depends on ccc_pkg.
module ccc_sqrt import ccc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        valid_i,
  input  logic [63:0] s_i,
  input  ccc_ctx_t    ctx_i,
  output logic        valid_o,
  output logic [31:0] m_o,
  output ccc_ctx_t    ctx_o
);

  logic        v_q    [SqrtSteps];
  logic [63:0] rem_q  [SqrtSteps];
  logic [63:0] root_q [SqrtSteps];
  ccc_ctx_t    ctx_q  [SqrtSteps];
  logic [63:0] rem_d  [SqrtSteps];
  logic [63:0] root_d [SqrtSteps];

  always_comb begin
    logic [63:0] r_in, o_in, bitv, trial;
    for (int k = 0; k < SqrtSteps; k++) begin
      if (k == 0) begin
        r_in = s_i;
        o_in = 64'd0;
      end else begin
        r_in = rem_q[k-1];
        o_in = root_q[k-1];
      end
      bitv  = 64'd1 << (62 - 2 * k);
      trial = o_in + bitv;
      if (r_in >= trial) begin
        rem_d[k]  = r_in - trial;
        root_d[k] = (o_in >> 1) + bitv;
      end else begin
        rem_d[k]  = r_in;
        root_d[k] = o_in >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SqrtSteps; k++) begin
        v_q[k] <= 1'b0;
      end
    end else if (adv_i) begin
      v_q[0] <= valid_i;
      for (int k = 1; k < SqrtSteps; k++) begin
        v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ctx_q[0] <= ctx_i;
      for (int k = 1; k < SqrtSteps; k++) begin
        ctx_q[k] <= ctx_q[k-1];
      end
      for (int k = 0; k < SqrtSteps; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
      end
    end
  end

  assign valid_o = v_q[SqrtSteps-1];
  assign m_o     = root_q[SqrtSteps-1][31:0];
  assign ctx_o   = ctx_q[SqrtSteps-1];

endmodule

// ----- rtl/core/ccc_div.sv -----
// Four-lane pipelined restoring divider, one quotient bit per register stage.
// All lanes share one divisor; depends on ccc_pkg.
module ccc_div import ccc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        valid_i,
  input  ccc_dw_t     num_i [DivLanes],
  input  logic [31:0] den_i,
  input  ccc_dctx_t   ctx_i,
  output logic        valid_o,
  output ccc_quo_t    quo_o [DivLanes],
  output ccc_dctx_t   ctx_o
);

  logic        v_q   [DivSteps];
  ccc_dw_t     rem_q [DivSteps][DivLanes];
  ccc_quo_t    quo_q [DivSteps][DivLanes];
  logic [31:0] den_q [DivSteps];
  ccc_dctx_t   ctx_q [DivSteps];
  ccc_dw_t     rem_d [DivSteps][DivLanes];
  ccc_quo_t    quo_d [DivSteps][DivLanes];

  // Stage k settles quotient bit DivSteps-1-k of every lane.
  always_comb begin
    ccc_dw_t     r_in, trial;
    ccc_quo_t    q_in;
    logic [31:0] d_in;
    for (int k = 0; k < DivSteps; k++) begin
      for (int l = 0; l < DivLanes; l++) begin
        if (k == 0) begin
          r_in = num_i[l];
          q_in = '0;
          d_in = den_i;
        end else begin
          r_in = rem_q[k-1][l];
          q_in = quo_q[k-1][l];
          d_in = den_q[k-1];
        end
        trial = 64'(d_in) << (DivSteps - 1 - k);
        if (r_in >= trial) begin
          rem_d[k][l] = r_in - trial;
          quo_d[k][l] = q_in | (31'd1 << (DivSteps - 1 - k));
        end else begin
          rem_d[k][l] = r_in;
          quo_d[k][l] = q_in;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DivSteps; k++) begin
        v_q[k] <= 1'b0;
      end
    end else if (adv_i) begin
      v_q[0] <= valid_i;
      for (int k = 1; k < DivSteps; k++) begin
        v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      den_q[0] <= den_i;
      ctx_q[0] <= ctx_i;
      for (int k = 1; k < DivSteps; k++) begin
        den_q[k] <= den_q[k-1];
        ctx_q[k] <= ctx_q[k-1];
      end
      for (int k = 0; k < DivSteps; k++) begin
        for (int l = 0; l < DivLanes; l++) begin
          rem_q[k][l] <= rem_d[k][l];
          quo_q[k][l] <= quo_d[k][l];
        end
      end
    end
  end

  assign valid_o = v_q[DivSteps-1];
  assign ctx_o   = ctx_q[DivSteps-1];
  always_comb begin
    for (int l = 0; l < DivLanes; l++) begin
      quo_o[l] = quo_q[DivSteps-1][l];
    end
  end

endmodule

// ----- tb/circle_circle_contact_core_test.sv -----
// Self-checking testbench for circle_circle_contact_core: random and directed circle pairs
// with handshake idling on both sides; results checked against an in-bench predictor.
// Depends on ccc_pkg and the RTL of the core.
module circle_circle_contact_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ccc_pkg::*;

  localparam int unsigned PipeDepth = 68;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned CalmTail = 150;

  typedef struct {
    logic signed [31:0] ax, ay, bx, by;
    logic [30:0]        ra, rb;
    bit                 drain;
  } pair_t;

  typedef struct {
    logic               hit;
    logic signed [15:0] nx, ny;
    logic signed [31:0] px, py;
    logic [31:0]        depth;
  } contact_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] a_x_i = '0, a_y_i = '0, b_x_i = '0, b_y_i = '0;
  logic [30:0] a_radius_i = '0, b_radius_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic hit_o;
  logic signed [15:0] normal_x_o, normal_y_o;
  logic signed [31:0] point_x_o, point_y_o;
  logic [31:0] depth_o;

  pair_t    pending_pairs[$];
  contact_t expected_contacts[$];
  int       mismatches = 0;
  int       send_gap = 0;
  int       recv_gap = 0;
  int       quiet_cycles = 0;

  always #6 clk_i = ~clk_i;

  circle_circle_contact_core uut (.*);

  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] rem, root, b;
    rem = v;
    root = '0;
    b = 64'd1 << 62;
    while (b > rem) b >>= 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  // Rounds |num| * mul / den half away from zero and restores the sign of num.
  function automatic longint scale_round(longint num, logic [63:0] mul, logic [63:0] den);
    logic [63:0] mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag * mul + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  function automatic contact_t predict_contact(pair_t p);
    contact_t c;
    longint dx, dy;
    logic [63:0] mx, my, rsum, m;
    logic [64:0] s;
    dx = longint'(p.bx) - longint'(p.ax);
    dy = longint'(p.by) - longint'(p.ay);
    mx = (dx < 0) ? -dx : dx;
    my = (dy < 0) ? -dy : dy;
    s = {1'b0, mx * mx} + {1'b0, my * my};
    rsum = 64'(p.ra) + 64'(p.rb);
    c = '{default: '0};
    if (s[64] || s == 0 || s[63:0] >= rsum * rsum) return c;
    m = floor_root(s[63:0]);
    c.hit = 1'b1;
    c.nx = 16'(clip(scale_round(dx, Q14One, m), -16384, 16384));
    c.ny = 16'(clip(scale_round(dy, Q14One, m), -16384, 16384));
    c.px = 32'(clip(longint'(p.ax) + scale_round(dx, 64'(p.ra), m),
                    -64'sd2147483648, 64'sd2147483647));
    c.py = 32'(clip(longint'(p.ay) + scale_round(dy, 64'(p.ra), m),
                    -64'sd2147483648, 64'sd2147483647));
    c.depth = 32'(rsum - m);
    return c;
  endfunction

  function automatic pair_t make_pair(int ax, int ay, int ra, int bx, int by, int rb);
    pair_t p;
    p.ax = ax; p.ay = ay; p.ra = ra[30:0];
    p.bx = bx; p.by = by; p.rb = rb[30:0];
    p.drain = 1'b0;
    return p;
  endfunction

  // Driver: a request stays on the bus unchanged until it is taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        pair_t sent;
        sent.ax = a_x_i; sent.ay = a_y_i; sent.ra = a_radius_i;
        sent.bx = b_x_i; sent.by = b_y_i; sent.rb = b_radius_i;
        expected_contacts.push_back(predict_contact(sent));
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_pairs.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (pending_pairs[0].drain &&
                     (expected_contacts.size() != 0 ||
                      (in_valid_i && in_ready_o))) begin
          in_valid_i <= 1'b0;
        end else if (pending_pairs.size() > CalmTail && $urandom_range(0, 9) == 0) begin
          send_gap <= $urandom_range(0, 8);
          in_valid_i <= 1'b0;
        end else begin
          pair_t p;
          p = pending_pairs.pop_front();
          in_valid_i <= 1'b1;
          a_x_i <= p.ax; a_y_i <= p.ay; a_radius_i <= p.ra;
          b_x_i <= p.bx; b_y_i <= p.by; b_radius_i <= p.rb;
        end
      end
    end
  end

  // Monitor and receiver stalls.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_contacts.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          contact_t e;
          e = expected_contacts.pop_front();
          if (hit_o !== e.hit) begin
            $error("hit: expected %0d, got %0d", e.hit, hit_o); mismatches++;
          end
          if (normal_x_o !== e.nx) begin
            $error("normal_x: expected %0d, got %0d", e.nx, normal_x_o); mismatches++;
          end
          if (normal_y_o !== e.ny) begin
            $error("normal_y: expected %0d, got %0d", e.ny, normal_y_o); mismatches++;
          end
          if (point_x_o !== e.px) begin
            $error("point_x: expected %0d, got %0d", e.px, point_x_o); mismatches++;
          end
          if (point_y_o !== e.py) begin
            $error("point_y: expected %0d, got %0d", e.py, point_y_o); mismatches++;
          end
          if (depth_o !== e.depth) begin
            $error("depth: expected %0d, got %0d", e.depth, depth_o); mismatches++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready_i <= 1'b0;
      end else if (pending_pairs.size() > CalmTail && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(0, 8);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    pair_t p;
    int base_x, base_y, span;
    // Directed: extremes, coincident centres, huge separation, exact touching,
    // normal clamping and saturated contact points.
    pending_pairs.push_back(make_pair(0, 0, 65536, 65536, 0, 65536));
    pending_pairs.push_back(make_pair(100, -200, 5000, 100, -200, 9000));
    pending_pairs.push_back(make_pair(32'sh8000_0000, 32'sh8000_0000, 0,
                                      2147483647, 2147483647, 0));
    pending_pairs.push_back(make_pair(32'sh8000_0000, 32'sh8000_0000, 2147483647,
                                      2147483647, 2147483647, 2147483647));
    pending_pairs.push_back(make_pair(32'sh8000_0000, 0, 2147483647,
                                      2147483647, 0, 2147483647));
    pending_pairs.push_back(make_pair(0, 0, 3, 3, 4, 2));
    pending_pairs.push_back(make_pair(0, 0, 3, 3, 4, 3));
    pending_pairs.push_back(make_pair(0, 0, 0, 1, 0, 2));
    pending_pairs.push_back(make_pair(0, 0, 1, 1, 1, 1));
    pending_pairs.push_back(make_pair(5, 5, 1, 6, 7, 2));
    pending_pairs.push_back(make_pair(2147483000, 2147483000, 2147483647,
                                      2147483647, 2147483647, 1000));
    pending_pairs.push_back(make_pair(-2147483000, -2147483000, 2147483647,
                                      32'sh8000_0000, 32'sh8000_0000, 1000));
    pending_pairs.push_back(make_pair(0, 0, 2147483647, -1, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, 2147483647, 0, -1, 0));
    pending_pairs.push_back(make_pair(1000, 1000, 2147483647, 1000, 1001, 2147483647));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(-1, -1, 7, 1, 1, 0));
    pending_pairs.push_back(make_pair(3, 3, 1, 2, 2, 1));
    for (int i = 0; i < 1350; i++) begin
      if ($urandom_range(0, 9) < 3) begin
        p = make_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        span = 1 << $urandom_range(0, 30);
        base_x = $urandom;
        base_y = $urandom;
        p = make_pair(base_x, base_y, $urandom_range(0, span),
                      base_x + $urandom_range(0, 2 * span) - span,
                      base_y + $urandom_range(0, 2 * span) - span,
                      $urandom_range(0, span));
        if ($urandom_range(0, 3) == 0) p.ra = 31'($urandom);
      end
      p.drain = (i == 400 || i == 900);
      pending_pairs.push_back(p);
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_pairs.size() == 0);
    @(posedge clk_i);
    while (in_valid_i || expected_contacts.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 12) @(posedge clk_i);
    if (mismatches == 0 && expected_contacts.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- circle_circle_contact_core.f -----
rtl/core/ccc_pkg.sv
rtl/core/ccc_front.sv
rtl/core/ccc_sqrt.sv
rtl/core/ccc_div.sv
rtl/core/circle_circle_contact_core.sv
tb/circle_circle_contact_core_test.sv
